// ===== rtl/pcc_pkg.sv =====
// pcc_pkg: shared types and constants for the power and code constants core
// used by power_and_code_constants_core and its checker; no dependencies
package pcc_pkg;

  localparam int FIELD_BITS        = 64;
  localparam int WORD_BITS_DEFAULT = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PICK,
    ST_POW_F,
    ST_POW_S,
    ST_SQUARE,
    ST_DIVIDE,
    ST_COUNT,
    ST_NIL,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/power_and_code_constants_core.sv =====
// power_and_code_constants_core: integer powers by square-and-multiply, quotient and code counts
// depends on pcc_pkg
//
// Usage: the input channel (in_valid / in_stall) carries base, length and sub_length.
// A transfer happens when in_valid is high and in_stall is low. The output channel
// (out_valid / out_stall) carries full_power, small_power, quotient, monomial_count,
// nil_position and divide_error, one result per input transfer.
// Only the low WORD_BITS bits of each input are used; results wrap modulo 2^WORD_BITS
// and are zero-extended onto the 64-bit output ports.
// Every product goes through one shared half-width multiplier; each WORD_BITS-wide
// product is summed from three partial products into its low word. Each exponent
// bit costs one pick step, one squaring and one product per set bit of length and
// sub_length; the loop stops when both exponents run out. The quotient then comes
// from a restoring divider, followed by two products for monomial_count and
// nil_position. The next input can be taken in the cycle after the result reaches
// the output register.
// in_stall stays high from the input transfer until the result has been moved to the
// output register; a waiting result does not block the next input transfer, but a
// second result waits until the first is taken. Reset empties the block.
module power_and_code_constants_core
  import pcc_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FIELD_BITS-1:0] base,
  input  logic [FIELD_BITS-1:0] length,
  input  logic [FIELD_BITS-1:0] sub_length,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FIELD_BITS-1:0] full_power,
  output logic [FIELD_BITS-1:0] small_power,
  output logic [FIELD_BITS-1:0] quotient,
  output logic [FIELD_BITS-1:0] monomial_count,
  output logic [FIELD_BITS-1:0] nil_position,
  output logic                  divide_error
);

  localparam int W  = WORD_BITS;
  localparam int H  = (WORD_BITS + 1) / 2;
  localparam int CW = $clog2(WORD_BITS);

  state_t state, state_next;

  // working registers
  logic [W-1:0] base_r, len, sub;
  logic [W-1:0] b, el, es, accf, accs;
  logic [W-1:0] rem, qreg, cnt_r, nil_r;
  logic [CW-1:0] dcnt;

  // shared multiplier
  logic [1:0]     mstep;
  logic [2*H-1:0] prod;
  logic [W-1:0]   acc;
  logic [W-1:0]   opa, opb;
  logic [H-1:0]   a_lo, a_hi, b_lo, b_hi, mx, my;
  logic [2*H-1:0] mul_p;
  logic [W-1:0]   shifted, mul_sum;
  logic           mul_state, mul_done;

  // divider
  logic [W:0]   shl, diff;
  logic         ge, div_last, err;
  logic [W-1:0] rem_next, qreg_next;

  logic out_free;

  assign err      = (sub == '0);
  assign out_free = !out_valid || !out_stall;

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_PICK;
      ST_PICK: begin
        if (el == '0 && es == '0) state_next = ST_DIVIDE;
        else if (el[0])           state_next = ST_POW_F;
        else if (es[0])           state_next = ST_POW_S;
        else                      state_next = ST_SQUARE;
      end
      ST_POW_F:  if (mul_done) state_next = es[0] ? ST_POW_S : ST_SQUARE;
      ST_POW_S:  if (mul_done) state_next = ST_SQUARE;
      ST_SQUARE: if (mul_done) state_next = ST_PICK;
      ST_DIVIDE: if (div_last) state_next = ST_COUNT;
      ST_COUNT:  if (mul_done) state_next = ST_NIL;
      ST_NIL:    if (mul_done) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_stall  = 1'b1;
    mul_state = 1'b0;
    opa       = b;
    opb       = b;
    case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_POW_F: begin
        mul_state = 1'b1;
        opa       = accf;
      end
      ST_POW_S: begin
        mul_state = 1'b1;
        opa       = accs;
      end
      ST_SQUARE: mul_state = 1'b1;
      ST_COUNT: begin
        mul_state = 1'b1;
        opa       = qreg;
        opb       = accs - W'(1);
      end
      ST_NIL: begin
        mul_state = 1'b1;
        opa       = len;
        opb       = base_r - W'(1);
      end
      default: ;
    endcase
  end

  assign mul_done = mul_state && (mstep == 2'd3);

  // low word of opa*opb from three half-width partial products
  assign a_lo = opa[H-1:0];
  assign a_hi = H'(opa >> H);
  assign b_lo = opb[H-1:0];
  assign b_hi = H'(opb >> H);

  always_comb begin
    case (mstep)
      2'd1:    begin mx = a_lo; my = b_hi; end
      2'd2:    begin mx = a_hi; my = b_lo; end
      default: begin mx = a_lo; my = b_lo; end
    endcase
  end

  assign mul_p   = mx * my;
  assign shifted = W'({prod, {H{1'b0}}});
  assign mul_sum = acc + shifted;

  // restoring division step
  assign shl       = {rem, qreg[W-1]};
  assign diff      = shl - {1'b0, sub};
  assign ge        = !diff[W];
  assign rem_next  = ge ? diff[W-1:0] : shl[W-1:0];
  assign qreg_next = {qreg[W-2:0], ge};
  assign div_last  = (state == ST_DIVIDE) && (dcnt == CW'(W - 1));

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mstep     <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_state) mstep <= mstep + 2'd1;
      else           mstep <= 2'd0;
      if (state == ST_FINISH && out_free) out_valid <= 1'b1;
      else if (!out_stall)                out_valid <= 1'b0;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (mul_state) begin
      case (mstep)
        2'd0:    prod <= mul_p;
        2'd1: begin
          prod <= mul_p;
          acc  <= W'(prod);
        end
        2'd2: begin
          prod <= mul_p;
          acc  <= mul_sum;
        end
        default: ;
      endcase
    end

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          base_r <= base[W-1:0];
          len    <= length[W-1:0];
          sub    <= sub_length[W-1:0];
          b      <= base[W-1:0];
          el     <= length[W-1:0];
          es     <= sub_length[W-1:0];
          accf   <= W'(1);
          accs   <= W'(1);
        end
      end
      ST_PICK: begin
        rem  <= '0;
        qreg <= len;
        dcnt <= '0;
      end
      ST_POW_F: if (mul_done) accf <= mul_sum;
      ST_POW_S: if (mul_done) accs <= mul_sum;
      ST_SQUARE: begin
        if (mul_done) begin
          b  <= mul_sum;
          el <= el >> 1;
          es <= es >> 1;
        end
      end
      ST_DIVIDE: begin
        rem  <= rem_next;
        qreg <= (div_last && err) ? '0 : qreg_next;
        dcnt <= dcnt + CW'(1);
      end
      ST_COUNT: if (mul_done) cnt_r <= err ? '0 : mul_sum + W'(1);
      ST_NIL:   if (mul_done) nil_r <= mul_sum + W'(1);
      ST_FINISH: begin
        if (out_free) begin
          full_power     <= FIELD_BITS'(accf);
          small_power    <= FIELD_BITS'(accs);
          quotient       <= FIELD_BITS'(qreg);
          monomial_count <= FIELD_BITS'(cnt_r);
          nil_position   <= FIELD_BITS'(nil_r);
          divide_error   <= err;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/pcc_checker.sv =====
// pcc_checker: port-level checks for power_and_code_constants_core, attached by bind
// depends on pcc_pkg
module pcc_checker
  import pcc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [FIELD_BITS-1:0] base,
  input logic [FIELD_BITS-1:0] length,
  input logic [FIELD_BITS-1:0] sub_length,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [FIELD_BITS-1:0] full_power,
  input logic [FIELD_BITS-1:0] small_power,
  input logic [FIELD_BITS-1:0] quotient,
  input logic [FIELD_BITS-1:0] monomial_count,
  input logic [FIELD_BITS-1:0] nil_position,
  input logic                  divide_error
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(full_power) && $stable(quotient))
    else $error("stalled result changed");

  // the block is busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while still working");

  // a new result only appears at the end of a computation
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a computation");

  // zero divisor clears quotient and count
  a_div_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error |-> quotient == '0 && monomial_count == '0)
    else $error("divide error with nonzero quotient or count");

endmodule

bind power_and_code_constants_core pcc_checker u_pcc_checker (.*);

// ===== sim/tb.sv =====
// tb: self-checking bench for power_and_code_constants_core, directed table plus random queries
// depends on pcc_pkg and the core; predicts untyped results with its own square-and-multiply
`timescale 1ns / 1ps

module tb;
  import pcc_pkg::*;

  localparam int          WB             = WORD_BITS_DEFAULT;
  localparam logic [63:0] ALL_ONES       = {64{1'b1}};
  localparam logic [63:0] TOP_BIT        = 64'h8000_0000_0000_0000;
  localparam logic [63:0] WORD_MASK      = ALL_ONES >> (64 - WB);
  localparam int          RANDOM_QUERIES = 1290;
  localparam int          PRESSURE_AT    = 60;
  localparam int          HOLD_CYCLES    = 3000;
  localparam int          QUIET_LIMIT    = 20000;
  localparam int          DRAIN_CYCLES   = 1000;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [63:0] sub_length;
  } query_t;

  typedef struct packed {
    logic [63:0] full_power;
    logic [63:0] small_power;
    logic [63:0] quotient;
    logic [63:0] monomial_count;
    logic [63:0] nil_position;
    logic        divide_error;
  } constants_t;

  typedef struct packed {
    query_t     q;
    logic       typed;
    constants_t want;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 16;

  // rows with typed results can be worked out by hand, the rest go through the predictor
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{64'd0, 64'd0, 64'd0}, 1'b1, '{64'd1, 64'd1, 64'd0, 64'd0, 64'd1, 1'b1}},
    '{'{64'd0, 64'd0, 64'd1}, 1'b1, '{64'd1, 64'd0, 64'd0, 64'd1, 64'd1, 1'b0}},
    '{'{64'd1, ALL_ONES, 64'd1}, 1'b1, '{64'd1, 64'd1, ALL_ONES, 64'd1, 64'd1, 1'b0}},
    '{'{ALL_ONES, ALL_ONES, ALL_ONES}, 1'b1,
      '{ALL_ONES, ALL_ONES, 64'd1, ALL_ONES, 64'd3, 1'b0}},
    '{'{64'd2, 64'd64, 64'd0}, 1'b1, '{64'd0, 64'd1, 64'd0, 64'd0, 64'd65, 1'b1}},
    '{'{64'd2, 64'd63, 64'd1}, 1'b1, '{TOP_BIT, 64'd2, 64'd63, 64'd64, 64'd64, 1'b0}},
    '{'{ALL_ONES, 64'd0, ALL_ONES}, 1'b1, '{64'd1, ALL_ONES, 64'd0, 64'd1, 64'd1, 1'b0}},
    '{'{64'd3, 64'd5, 64'd2}, 1'b1, '{64'd243, 64'd9, 64'd2, 64'd17, 64'd11, 1'b0}},
    '{'{64'd0, ALL_ONES, ALL_ONES}, 1'b1, '{64'd0, 64'd0, 64'd1, 64'd0, 64'd2, 1'b0}},
    '{'{TOP_BIT, 64'd1, 64'd2}, 1'b1, '{TOP_BIT, 64'd0, 64'd0, 64'd1, TOP_BIT, 1'b0}},
    '{'{ALL_ONES, ALL_ONES, 64'd0}, 1'b1,
      '{ALL_ONES, 64'd1, 64'd0, 64'd0, 64'd3, 1'b1}},
    '{'{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'd3}, 1'b0, '0},
    '{'{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, TOP_BIT}, 1'b0, '0},
    '{'{64'd3, TOP_BIT, ALL_ONES}, 1'b0, '0},
    '{'{64'd7, 64'd1000, 64'd10}, 1'b0, '0},
    '{'{ALL_ONES - 64'd1, 64'd12345, 64'd1}, 1'b0, '0}
  };

  logic        clk;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [63:0] base       = '0;
  logic [63:0] length     = '0;
  logic [63:0] sub_length = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [63:0] full_power;
  logic [63:0] small_power;
  logic [63:0] quotient;
  logic [63:0] monomial_count;
  logic [63:0] nil_position;
  logic        divide_error;

  constants_t expected_constants [$];
  int         mismatches      = 0;
  int         queries_taken   = 0;
  int         results_checked = 0;
  int         zero_divisors   = 0;
  int         wide_exponents  = 0;
  int         idle_pct        = 0;
  int         stall_pct       = 0;
  int         quiet_cycles    = 0;
  bit         hold_done       = 1'b0;

  power_and_code_constants_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .base           (base),
    .length         (length),
    .sub_length     (sub_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .full_power     (full_power),
    .small_power    (small_power),
    .quotient       (quotient),
    .monomial_count (monomial_count),
    .nil_position   (nil_position),
    .divide_error   (divide_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] wrap_power(logic [63:0] b, logic [63:0] e);
    logic [63:0] acc;
    acc = 64'd1;
    for (int i = 0; i < 64; i++) begin
      if (e[i]) acc = (acc * b) & WORD_MASK;
      b = (b * b) & WORD_MASK;
    end
    return acc & WORD_MASK;
  endfunction

  function automatic constants_t compute_code_constants(query_t q);
    constants_t  r;
    logic [63:0] p;
    logic [63:0] l;
    logic [63:0] lam;
    p = q.base & WORD_MASK;
    l = q.length & WORD_MASK;
    lam = q.sub_length & WORD_MASK;
    r.full_power   = wrap_power(p, l);
    r.small_power  = wrap_power(p, lam);
    r.divide_error = (lam == 64'd0);
    if (r.divide_error) begin
      r.quotient       = '0;
      r.monomial_count = '0;
    end else begin
      r.quotient       = (l / lam) & WORD_MASK;
      r.monomial_count = (r.quotient * ((r.small_power - 64'd1) & WORD_MASK) + 64'd1) & WORD_MASK;
    end
    r.nil_position = (l * ((p - 64'd1) & WORD_MASK) + 64'd1) & WORD_MASK;
    return r;
  endfunction

  // mostly short exponents so the square-and-multiply loop stays brief
  function automatic logic [63:0] random_exponent();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0:       return w;
      1:       return 64'd0;
      2:       return 64'd1;
      default: return w & ((64'd1 << $urandom_range(1, 12)) - 64'd1);
    endcase
  endfunction

  function automatic logic [63:0] random_base();
    case ($urandom_range(0, 7))
      0:       return 64'($urandom_range(0, 3));
      1:       return ALL_ONES;
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic offer(input query_t q, input constants_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    base       <= q.base;
    length     <= q.length;
    sub_length <= q.sub_length;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_constants.push_back(want);
    queries_taken++;
    if (q.sub_length == 64'd0) zero_divisors++;
    if ((q.length | q.sub_length) >> 12 != 64'd0) wide_exponents++;
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  // output side: random stalls, plus one long hold while the input keeps offering
  initial begin
    forever begin
      @(negedge clk);
      if (!hold_done && queries_taken >= PRESSURE_AT) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    constants_t want;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (expected_constants.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing expected, full_power %h",
                 $time, full_power);
      end else begin
        want = expected_constants.pop_front();
        check_field("full_power", want.full_power, full_power);
        check_field("small_power", want.small_power, small_power);
        check_field("quotient", want.quotient, quotient);
        check_field("monomial_count", want.monomial_count, monomial_count);
        check_field("nil_position", want.nil_position, nil_position);
        check_field("divide_error", 64'(want.divide_error), 64'(divide_error));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int     idle_of  [4] = '{0, 59, 0, 17};
    int     stall_of [4] = '{0, 0, 59, 17};
    int     phase;
    query_t q;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int n = 0; n < DIRECTED_ROWS; n++) begin
      offer(directed_rows[n].q, directed_rows[n].typed ? directed_rows[n].want
                                                        : compute_code_constants(directed_rows[n].q));
    end

    for (int n = 0; n < RANDOM_QUERIES; n++) begin
      phase     = n * 4 / RANDOM_QUERIES;
      idle_pct  = idle_of[phase];
      stall_pct = stall_of[phase];
      q.base       = random_base();
      q.length     = random_exponent();
      q.sub_length = random_exponent();
      offer(q, compute_code_constants(q));
    end
    in_valid <= 1'b0;

    while (expected_constants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d queries and %0d results: %0d with zero sub_length, %0d with wide exponents",
             queries_taken, results_checked, zero_divisors, wide_exponents);
    $display("idling phases none, input 59%%, output 59%%, both 17%%, plus one %0d-cycle output hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pcc_pkg.sv
rtl/power_and_code_constants_core.sv
rtl/pcc_checker.sv
sim/tb.sv
